[rtl/twcr_pkg.sv]
// Package for the textured wall column renderer.
// Holds the fixed field widths, the stream bit positions, opcodes, register indexes
// and the saturation helper. It depends on nothing else.
package twcr_pkg;

   // Widths of the transaction fields.
   localparam int OPCODE_W     = 2;
   localparam int COORD_W      = 32;
   localparam int PD_W         = 31;
   localparam int TSEL_IN_W    = 2;
   localparam int LH_W         = 16;
   localparam int DRAW_W       = 11;
   localparam int TEX_ADDR_W   = 12;
   localparam int COLOR_W      = 24;
   localparam int ROW_OUT_W    = 10;
   localparam int FRAC_BITS    = 16;

   // Request payload layout, lowest bit first.
   localparam int SIDE_LSB     = 0;
   localparam int PA_LSB       = 1;
   localparam int PD_LSB       = 33;
   localparam int RDX_LSB      = 64;
   localparam int RDY_LSB      = 96;
   localparam int TSEL_LSB     = 128;
   localparam int LH_LSB       = 130;
   localparam int DS_LSB       = 146;
   localparam int DE_LSB       = 157;
   localparam int TADDR_LSB    = 168;
   localparam int TCOLOR_LSB   = 180;
   localparam int REQ_TDATA_W  = 208;

   // Response payload layout: row, then color, padded to whole bytes.
   localparam int RSP_FIELDS_W = ROW_OUT_W + COLOR_W;
   localparam int RSP_TDATA_W  = 40;

   // Configuration port.
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 24;
   localparam int SCREEN_REG_W  = 11;
   localparam int SIZE_REG_W    = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CEILING_COLOR  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOOR_COLOR    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXTURE_WIDTH  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXTURE_HEIGHT = 3'd4;

   localparam logic [SCREEN_REG_W-1:0] SCREEN_HEIGHT_RST = 11'd480;
   localparam logic [SIZE_REG_W-1:0]   TEX_SIZE_RST      = 7'd64;

   // Operation codes carried in tuser.
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PIXEL = 2'd2;

   // Shared datapath widths.
   localparam int ACC_W = 48;
   localparam int MPL_W = 32;

   // Clamp a signed accumulator value into the signed 32-bit range.
   function automatic logic [COORD_W-1:0] sat32(input logic [ACC_W-1:0] v);
      logic fits_pos;
      logic fits_neg;
      fits_pos = (v[ACC_W-1:COORD_W-1] == '0);
      fits_neg = (v[ACC_W-1:COORD_W-1] == '1);
      if (fits_pos || fits_neg) begin
         return v[COORD_W-1:0];
      end else if (!v[ACC_W-1]) begin
         return 32'h7FFF_FFFF;
      end else begin
         return 32'h8000_0000;
      end
   endfunction

endpackage

[rtl/textured_wall_column_renderer.sv]
// Top level of the textured wall column renderer: texture store, column setup
// sequencer around one shared adder, and pixel output register.
// Depends on twcr_pkg.
//
// Usage: requests arrive on req_* with the opcode in req_tuser. A load writes one
// texel into the on-chip texture store. A begin-column transaction sets up the
// texel column, the texture step and the start position of one screen column. Each
// next-pixel transaction returns one row on rsp_*, with rsp_tlast on the bottom row;
// a next-pixel with no open column returns nothing.
// Steps per transaction, from acceptance to the next acceptance:
//   next pixel   address and texture read, then the output register is loaded,
//   load         address modulo TEX_DIM^2 by repeated subtract, then the write,
//   begin column the multiplies and the divide described below.
// Begin column runs a shift-add multiply for the wall fraction (31 steps), one for
// the texel column (16 steps), a restoring divide for the step and a shift-add
// multiply for the start position, all through the same 48-bit adder.
// req_tready is high only while the sequencer is idle. A pixel result waits in its
// output cycle while rsp_tvalid is high and rsp_tready is low; a held result does
// not block the next request from being accepted.
// Reset (synchronous) restores the register defaults and closes the column; the
// texture store is not cleared, and rows read from unwritten texels are undefined.
module textured_wall_column_renderer
   import twcr_pkg::*;
#(
   parameter int NUM_TEXTURES = 4,
   parameter int TEX_DIM      = 64,
   parameter int MAX_ROWS     = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata fields from bit 0: side, player_along, perp_dist, ray_dx, ray_dy,
   // tex_select, line_height, draw_start, draw_end, texel_address, texel_color.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser fields from bit 0: opcode.
   input  logic [OPCODE_W-1:0]    req_tuser,
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata fields from bit 0: row, color.
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TEX_AREA  = TEX_DIM * TEX_DIM;
   localparam int MEM_DEPTH = NUM_TEXTURES * TEX_AREA;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int COL_W     = $clog2(TEX_DIM);
   localparam int TW_W      = $clog2(TEX_DIM + 1);
   localparam int DIMC_W    = (TW_W > SIZE_REG_W) ? TW_W : SIZE_REG_W;
   localparam int RO_W      = COL_W + TW_W;
   localparam int TSEL_W    = (NUM_TEXTURES > 1) ? $clog2(NUM_TEXTURES) : 1;
   localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
   localparam int ROW_W     = (ROW_CW > SCREEN_REG_W) ? ROW_CW : SCREEN_REG_W;
   localparam int DIV_W     = TW_W + FRAC_BITS;
   localparam int MAX_STEPS = (DIV_W > PD_W) ? DIV_W : PD_W;
   localparam int CNT_W     = $clog2(MAX_STEPS);
   localparam int BASE_W    = 18;
   localparam int SEL_WK_W  = 4;
   localparam int POS_W     = COORD_W + 2;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_FRAC = 7'b0000100,
      S_COL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_POS  = 7'b0100000,
      S_PIX  = 7'b1000000
   } state_type;

   // Request fields.
   logic                  in_side;
   logic [COORD_W-1:0]    in_player_along;
   logic [PD_W-1:0]       in_perp_dist;
   logic [COORD_W-1:0]    in_ray_dx;
   logic [COORD_W-1:0]    in_ray_dy;
   logic [TSEL_IN_W-1:0]  in_tex_select;
   logic [LH_W-1:0]       in_line_height;
   logic [DRAW_W-1:0]     in_draw_start;
   logic [DRAW_W-1:0]     in_draw_end;
   logic [TEX_ADDR_W-1:0] in_texel_address;
   logic [COLOR_W-1:0]    in_texel_color;

   assign in_side          = req_tdata[SIDE_LSB];
   assign in_player_along  = req_tdata[PA_LSB +: COORD_W];
   assign in_perp_dist     = req_tdata[PD_LSB +: PD_W];
   assign in_ray_dx        = req_tdata[RDX_LSB +: COORD_W];
   assign in_ray_dy        = req_tdata[RDY_LSB +: COORD_W];
   assign in_tex_select    = req_tdata[TSEL_LSB +: TSEL_IN_W];
   assign in_line_height   = req_tdata[LH_LSB +: LH_W];
   assign in_draw_start    = req_tdata[DS_LSB +: DRAW_W];
   assign in_draw_end      = req_tdata[DE_LSB +: DRAW_W];
   assign in_texel_address = req_tdata[TADDR_LSB +: TEX_ADDR_W];
   assign in_texel_color   = req_tdata[TCOLOR_LSB +: COLOR_W];

   // Configuration registers.
   logic [SCREEN_REG_W-1:0] screen_height_ff;
   logic [COLOR_W-1:0]      ceiling_color_ff;
   logic [COLOR_W-1:0]      floor_color_ff;
   logic [SIZE_REG_W-1:0]   texture_width_ff;
   logic [SIZE_REG_W-1:0]   texture_height_ff;

   // Sequencer and column state.
   state_type              state_ff, state_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]       mcand_ff, mcand_in;
   logic [MPL_W-1:0]       mplier_ff, mplier_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   mirror_ff, mirror_in;
   logic [LH_W-1:0]        lh_ff, lh_in;
   logic [DRAW_W-1:0]      ds_ff, ds_in;
   logic [DRAW_W-1:0]      de_ff, de_in;
   logic [TSEL_W-1:0]      tsel_ff, tsel_in;
   logic [COLOR_W-1:0]     ld_color_ff, ld_color_in;
   logic [ROW_W-1:0]       current_row_ff, current_row_in;
   logic [COL_W-1:0]       texel_column_ff, texel_column_in;
   logic [COORD_W-1:0]     tex_position_ff, tex_position_in;
   logic [DIV_W-1:0]       tex_step_ff, tex_step_in;
   logic [TSEL_W-1:0]      column_texture_ff, column_texture_in;
   logic [DRAW_W-1:0]      slice_start_ff, slice_start_in;
   logic [DRAW_W-1:0]      slice_end_ff, slice_end_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;

   // Derived values.
   logic [DIMC_W-1:0]    tw_ext, th_ext;
   logic [TW_W-1:0]      tw_eff, th_eff, tw_m1, th_m1;
   logic [ROW_W-1:0]     sh_ext, rows_eff;
   logic [SEL_WK_W-1:0]  sel_work;
   logic [TSEL_W-1:0]    tsel_red;
   logic                 in_mirror;
   logic [LH_W-1:0]      lh1;
   logic [BASE_W-1:0]    base;
   logic                 mul_mode, div_mode;
   logic [ACC_W-1:0]     alu_a, alu_b, alu_sum;
   logic                 alu_neg;
   logic [MPL_W-1:0]     q_next;
   logic [COL_W-1:0]     col_raw;
   logic [FRAC_BITS-1:0] ty_raw;
   logic [COL_W-1:0]     tex_row, tex_col;
   logic [RO_W-1:0]      row_off;
   logic [MEM_AW-1:0]    rd_addr, wr_addr;
   logic                 mem_we;
   logic [COLOR_W-1:0]   rd_data_ff;
   logic [POS_W-1:0]     pos_sum;
   logic [COORD_W-1:0]   pos_adv;
   logic                 row_done, is_floor, is_ceil, is_tex, out_free, out_load;
   logic [COLOR_W-1:0]   pix_color;

   logic [COLOR_W-1:0]   tex_mem [MEM_DEPTH];

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff  <= SCREEN_HEIGHT_RST;
         ceiling_color_ff  <= '0;
         floor_color_ff    <= '0;
         texture_width_ff  <= TEX_SIZE_RST;
         texture_height_ff <= TEX_SIZE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_wdata[SCREEN_REG_W-1:0];
            CSR_CEILING_COLOR:  ceiling_color_ff  <= csr_wdata[COLOR_W-1:0];
            CSR_FLOOR_COLOR:    floor_color_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_TEXTURE_WIDTH:  texture_width_ff  <= csr_wdata[SIZE_REG_W-1:0];
            CSR_TEXTURE_HEIGHT: texture_height_ff <= csr_wdata[SIZE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes: zero acts as one, oversize values clamp to the maximum.
   always_comb begin
      tw_ext = DIMC_W'(texture_width_ff);
      th_ext = DIMC_W'(texture_height_ff);
      sh_ext = ROW_W'(screen_height_ff);
      if (tw_ext == '0) begin
         tw_eff = TW_W'(1);
      end else if (tw_ext > DIMC_W'(TEX_DIM)) begin
         tw_eff = TW_W'(TEX_DIM);
      end else begin
         tw_eff = TW_W'(tw_ext);
      end
      if (th_ext == '0) begin
         th_eff = TW_W'(1);
      end else if (th_ext > DIMC_W'(TEX_DIM)) begin
         th_eff = TW_W'(TEX_DIM);
      end else begin
         th_eff = TW_W'(th_ext);
      end
      if (sh_ext == '0) begin
         rows_eff = ROW_W'(1);
      end else if (sh_ext > ROW_W'(MAX_ROWS)) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = sh_ext;
      end
      tw_m1 = tw_eff - TW_W'(1);
      th_m1 = th_eff - TW_W'(1);
   end

   // Texture selector reduced modulo the number of textures.
   always_comb begin
      sel_work = SEL_WK_W'(in_tex_select);
      for (int i = 0; i < 3; i++) begin
         if (sel_work >= SEL_WK_W'(NUM_TEXTURES)) begin
            sel_work = sel_work - SEL_WK_W'(NUM_TEXTURES);
         end
      end
      tsel_red = TSEL_W'(sel_work);
   end

   // The column is mirrored when the ray faces away along the wall.
   assign in_mirror = (!in_side && !in_ray_dx[COORD_W-1] && (in_ray_dx != '0)) ||
                      (in_side && in_ray_dy[COORD_W-1]);

   // Line height of zero counts as one; start row offset for the texture position.
   assign lh1  = (lh_ff == '0) ? LH_W'(1) : lh_ff;
   assign base = BASE_W'(ds_ff) - BASE_W'(rows_eff >> 1) + BASE_W'(lh1 >> 1);

   // Shared adder: multiply steps add the shifted multiplicand when the multiplier
   // bit is set, divide steps subtract the divisor from the shifted remainder, and
   // the load modulo subtracts the texture area.
   assign mul_mode = (state_ff == S_FRAC) || (state_ff == S_COL) || (state_ff == S_POS);
   assign div_mode = (state_ff == S_DIV);
   assign alu_a    = div_mode ? {acc_ff[ACC_W-2:0], mplier_ff[DIV_W-1]} : acc_ff;
   assign alu_b    = (mul_mode && !mplier_ff[0]) ? '0 : mcand_ff;
   assign alu_sum  = alu_a + alu_b;
   assign alu_neg  = alu_sum[ACC_W-1];
   assign q_next   = {mplier_ff[MPL_W-2:0], !alu_neg};
   assign col_raw  = alu_sum[FRAC_BITS +: COL_W];

   // Texture read address from the current column state.
   always_comb begin
      ty_raw = tex_position_ff[COORD_W-2:FRAC_BITS-1] >> 1;
      ty_raw = tex_position_ff[FRAC_BITS +: FRAC_BITS] & {1'b0, {(FRAC_BITS-1){1'b1}}};
      if (tex_position_ff[COORD_W-1]) begin
         tex_row = '0;
      end else if (ty_raw > FRAC_BITS'(th_m1)) begin
         tex_row = COL_W'(th_m1);
      end else begin
         tex_row = COL_W'(ty_raw);
      end
      if (TW_W'(texel_column_ff) > tw_m1) begin
         tex_col = COL_W'(tw_m1);
      end else begin
         tex_col = texel_column_ff;
      end
      row_off = RO_W'(tex_row) * RO_W'(tw_eff);
      rd_addr = MEM_AW'(column_texture_ff) * MEM_AW'(TEX_AREA) + MEM_AW'(row_off) +
                MEM_AW'(tex_col);
      wr_addr = MEM_AW'(tsel_ff) * MEM_AW'(TEX_AREA) + MEM_AW'(acc_ff[TEX_ADDR_W-1:0]);
   end

   // Texture store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem[wr_addr] <= ld_color_ff;
      end
      rd_data_ff <= tex_mem[rd_addr];
   end

   // Pixel classification and saturating texture position advance.
   always_comb begin
      row_done  = current_row_ff >= rows_eff;
      is_floor  = current_row_ff >= ROW_W'(slice_end_ff);
      is_ceil   = current_row_ff < ROW_W'(slice_start_ff);
      is_tex    = !is_floor && !is_ceil;
      pix_color = is_floor ? floor_color_ff : (is_ceil ? ceiling_color_ff : rd_data_ff);
      out_free  = !rsp_tvalid_ff || rsp_tready;
      out_load  = (state_ff == S_PIX) && !row_done && out_free;
      pos_sum   = {{2{tex_position_ff[COORD_W-1]}}, tex_position_ff} + POS_W'(tex_step_ff);
      if (!pos_sum[POS_W-1] && (pos_sum[POS_W-2:COORD_W-1] != '0)) begin
         pos_adv = 32'h7FFF_FFFF;
      end else begin
         pos_adv = pos_sum[COORD_W-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in          = state_ff;
      acc_in            = acc_ff;
      mcand_in          = mcand_ff;
      mplier_in         = mplier_ff;
      cnt_in            = cnt_ff;
      mirror_in         = mirror_ff;
      lh_in             = lh_ff;
      ds_in             = ds_ff;
      de_in             = de_ff;
      tsel_in           = tsel_ff;
      ld_color_in       = ld_color_ff;
      current_row_in    = current_row_ff;
      texel_column_in   = texel_column_ff;
      tex_position_in   = tex_position_ff;
      tex_step_in       = tex_step_ff;
      column_texture_in = column_texture_ff;
      slice_start_in    = slice_start_ff;
      slice_end_in      = slice_end_ff;
      mem_we            = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  OP_LOAD: begin
                     acc_in      = ACC_W'(in_texel_address);
                     mcand_in    = -(ACC_W'(TEX_AREA));
                     ld_color_in = in_texel_color;
                     tsel_in     = tsel_red;
                     state_in    = S_LOAD;
                  end
                  OP_BEGIN: begin
                     acc_in    = ACC_W'({in_player_along[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
                     mcand_in  = ACC_W'(in_side ? in_ray_dx : in_ray_dy);
                     mplier_in = MPL_W'(in_perp_dist);
                     cnt_in    = CNT_W'(PD_W - 1);
                     mirror_in = in_mirror;
                     lh_in     = in_line_height;
                     ds_in     = in_draw_start;
                     de_in     = in_draw_end;
                     tsel_in   = tsel_red;
                     state_in  = S_FRAC;
                  end
                  OP_PIXEL: begin
                     state_in = S_PIX;
                  end
                  default: ;
               endcase
            end
         end

         // Reduce the load address modulo one texture, then write.
         S_LOAD: begin
            if (alu_neg) begin
               mem_we   = 1'b1;
               state_in = S_IDLE;
            end else begin
               acc_in = alu_sum;
            end
         end

         // Wall hit fraction: player coordinate plus distance times ray component.
         S_FRAC: begin
            acc_in    = alu_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               acc_in    = '0;
               mcand_in  = ACC_W'(tw_eff);
               mplier_in = MPL_W'(alu_sum[COORD_W-1:FRAC_BITS]);
               cnt_in    = CNT_W'(FRAC_BITS - 1);
               state_in  = S_COL;
            end
         end

         // Texel column: fraction times width, mirrored when required.
         S_COL: begin
            acc_in    = alu_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               texel_column_in = mirror_ff ? COL_W'(tw_m1 - TW_W'(col_raw)) : col_raw;
               acc_in          = '0;
               mcand_in        = -(ACC_W'(lh1));
               mplier_in       = MPL_W'(DIV_W'(th_eff) << FRAC_BITS);
               cnt_in          = CNT_W'(DIV_W - 1);
               state_in        = S_DIV;
            end
         end

         // Texture step: restoring divide of height by line height.
         S_DIV: begin
            acc_in    = alu_neg ? alu_a : alu_sum;
            mplier_in = q_next;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               tex_step_in = q_next[DIV_W-1:0];
               acc_in      = '0;
               mcand_in    = {{(ACC_W-BASE_W){base[BASE_W-1]}}, base};
               mplier_in   = MPL_W'(q_next[DIV_W-1:0]);
               cnt_in      = CNT_W'(DIV_W - 1);
               state_in    = S_POS;
            end
         end

         // Start position: signed row offset times step, then open the column.
         S_POS: begin
            acc_in    = alu_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               tex_position_in   = sat32(alu_sum);
               current_row_in    = '0;
               slice_start_in    = ds_ff;
               slice_end_in      = de_ff;
               column_texture_in = tsel_ff;
               state_in          = S_IDLE;
            end
         end

         // Emit one row once the output register is free.
         S_PIX: begin
            if (row_done) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               current_row_in = current_row_ff + ROW_W'(1);
               if (is_tex) begin
                  tex_position_in = pos_adv;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_TDATA_W'({pix_color, current_row_ff[ROW_OUT_W-1:0]});
         rsp_tlast_in  = (current_row_ff == rows_eff - ROW_W'(1));
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Control and column state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_tvalid_ff     <= 1'b0;
         current_row_ff    <= ROW_W'(SCREEN_HEIGHT_RST);
         texel_column_ff   <= '0;
         tex_position_ff   <= '0;
         tex_step_ff       <= '0;
         column_texture_ff <= '0;
         slice_start_ff    <= '0;
         slice_end_ff      <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_tvalid_ff     <= rsp_tvalid_in;
         current_row_ff    <= current_row_in;
         texel_column_ff   <= texel_column_in;
         tex_position_ff   <= tex_position_in;
         tex_step_ff       <= tex_step_in;
         column_texture_ff <= column_texture_in;
         slice_start_ff    <= slice_start_in;
         slice_end_ff      <= slice_end_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      cnt_ff       <= cnt_in;
      mirror_ff    <= mirror_in;
      lh_ff        <= lh_in;
      ds_ff        <= ds_in;
      de_ff        <= de_in;
      tsel_ff      <= tsel_in;
      ld_color_ff  <= ld_color_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   // A new result only appears after a pixel output cycle.
   a_rsp_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_PIX))
      else $error("result appeared without a pixel transaction");

   // The divide never leaves a zero step, since height is at least one texel.
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && $past(state_ff == S_POS) |-> (tex_step_ff != '0))
      else $error("texture step is zero after column setup");

   // The row counter moves only on an emitted row or on opening a column.
   a_row_moves: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (current_row_ff != $past(current_row_ff)) |->
         $past(out_load) || $past(state_ff == S_POS))
      else $error("current row changed outside a pixel or column setup");

endmodule
